[rtl/core/sfp_pkg.sv]
// Shared types, codes and byte constants of the SysEx frame parser.
`default_nettype none

package sfp_pkg;

  // Width of the counter values carried on the result channel.
  localparam int unsigned CntOutW = 32;

  // MIDI byte values that steer the framing.
  localparam logic [7:0] ByteRealtimeMin = 8'hF8;
  localparam logic [7:0] ByteSysexStart  = 8'hF0;
  localparam logic [7:0] ByteSysexEnd    = 8'hF7;
  localparam logic [7:0] ByteStatusMin   = 8'h80;

  typedef logic [CntOutW-1:0] cnt_out_t;

  typedef enum logic [1:0] {
    OpByte  = 2'd0,
    OpLoss  = 2'd1,
    OpEnd   = 2'd2,
    OpReset = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KindRealtime = 2'd0,
    KindFrame    = 2'd1,
    KindClose    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StatusNone       = 2'd0,
    StatusComplete   = 2'd1,
    StatusIncomplete = 2'd2,
    StatusMalformed  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CauseNone          = 4'd0,
    CauseStrayEnd      = 4'd1,
    CauseStrayByte     = 4'd2,
    CauseNestedStart   = 4'd3,
    CauseLoss          = 4'd4,
    CauseStatusInside  = 4'd5,
    CauseUnterminated  = 4'd6,
    CauseUntermLoss    = 4'd7,
    CauseLossNoFrame   = 4'd8
  } cause_e;

  // Per-result fields.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       last;
    status_e    status;
    cause_e     cause;
    logic       loss;
  } res_t;

  // One queued record: a result, an optional following frame start byte,
  // and the counter values after the step that produced it.
  typedef struct packed {
    res_t     res;
    logic     then_start;
    cnt_out_t frames_ok;
    cnt_out_t bytes_ok;
    cnt_out_t frames_unterm;
    cnt_out_t frames_bad;
    cnt_out_t rt_passed;
    cnt_out_t loss_events;
  } rec_t;

endpackage

`default_nettype wire

[rtl/core/sfp_front.sv]
// Front end: accepts requests, tracks frame state and counters, builds result records.
`default_nettype none

module sfp_front #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    op_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output sfp_pkg::rec_t      rec_o
);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // Saturating add at the counter width.
  function automatic cnt_t sat_add(cnt_t a, cnt_t b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  localparam cnt_t CntOne = cnt_t'(1);
  localparam cnt_t CntTwo = cnt_t'(2);

  logic in_frame_q, in_frame_d;
  logic frame_loss_q, frame_loss_d;
  logic pending_loss_q, pending_loss_d;
  // Frame length that the next frame byte would give.
  cnt_t next_len_q, next_len_d;
  cnt_t cf_q, cf_d, cb_q, cb_d, inc_q, inc_d, mal_q, mal_d, rt_q, rt_d, le_q, le_d;

  logic          accept;
  sfp_pkg::res_t res;
  logic          then_start;
  logic          push;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the request and compute the next state and the result.
  always_comb begin
    in_frame_d     = in_frame_q;
    frame_loss_d   = frame_loss_q;
    pending_loss_d = pending_loss_q;
    next_len_d     = next_len_q;
    cf_d  = cf_q;
    cb_d  = cb_q;
    inc_d = inc_q;
    mal_d = mal_q;
    rt_d  = rt_q;
    le_d  = le_q;
    push       = 1'b0;
    then_start = 1'b0;
    res.kind     = sfp_pkg::KindFrame;
    res.out_byte = data_byte_i;
    res.last     = 1'b0;
    res.status   = sfp_pkg::StatusNone;
    res.cause    = sfp_pkg::CauseNone;
    res.loss     = 1'b0;

    case (sfp_pkg::op_e'(op_i))
      sfp_pkg::OpByte: begin
        push = 1'b1;
        if (data_byte_i >= sfp_pkg::ByteRealtimeMin) begin
          rt_d     = sat_add(rt_q, CntOne);
          res.kind = sfp_pkg::KindRealtime;
        end else if (!in_frame_q) begin
          if (data_byte_i == sfp_pkg::ByteSysexStart) begin
            in_frame_d     = 1'b1;
            next_len_d     = CntTwo;
            frame_loss_d   = pending_loss_q;
            pending_loss_d = 1'b0;
            res.loss       = pending_loss_q;
          end else begin
            mal_d      = sat_add(mal_q, CntOne);
            res.last   = 1'b1;
            res.status = sfp_pkg::StatusMalformed;
            res.cause  = (data_byte_i == sfp_pkg::ByteSysexEnd) ?
                         sfp_pkg::CauseStrayEnd : sfp_pkg::CauseStrayByte;
          end
        end else if (data_byte_i == sfp_pkg::ByteSysexStart) begin
          // Nested start: close the open frame, then open a fresh one.
          mal_d        = sat_add(mal_q, CntOne);
          res.kind     = sfp_pkg::KindClose;
          res.out_byte = 8'h00;
          res.last     = 1'b1;
          res.status   = sfp_pkg::StatusMalformed;
          res.cause    = sfp_pkg::CauseNestedStart;
          res.loss     = frame_loss_q;
          then_start   = 1'b1;
          next_len_d   = CntTwo;
          frame_loss_d = 1'b0;
        end else if (data_byte_i == sfp_pkg::ByteSysexEnd) begin
          res.last = 1'b1;
          if (frame_loss_q) begin
            mal_d      = sat_add(mal_q, CntOne);
            res.status = sfp_pkg::StatusMalformed;
            res.cause  = sfp_pkg::CauseLoss;
            res.loss   = 1'b1;
          end else begin
            cf_d       = sat_add(cf_q, CntOne);
            cb_d       = sat_add(cb_q, next_len_q);
            res.status = sfp_pkg::StatusComplete;
          end
          in_frame_d   = 1'b0;
          frame_loss_d = 1'b0;
          next_len_d   = CntOne;
        end else if (data_byte_i >= sfp_pkg::ByteStatusMin) begin
          mal_d        = sat_add(mal_q, CntOne);
          res.last     = 1'b1;
          res.status   = sfp_pkg::StatusMalformed;
          res.cause    = sfp_pkg::CauseStatusInside;
          res.loss     = frame_loss_q;
          in_frame_d   = 1'b0;
          frame_loss_d = 1'b0;
          next_len_d   = CntOne;
        end else begin
          res.loss   = frame_loss_q;
          next_len_d = sat_add(next_len_q, CntOne);
        end
      end
      sfp_pkg::OpLoss: begin
        le_d = sat_add(le_q, CntOne);
        if (in_frame_q) begin
          frame_loss_d = 1'b1;
        end else begin
          pending_loss_d = 1'b1;
        end
      end
      sfp_pkg::OpEnd: begin
        res.kind     = sfp_pkg::KindClose;
        res.out_byte = 8'h00;
        res.last     = 1'b1;
        if (in_frame_q) begin
          push = 1'b1;
          if (frame_loss_q) begin
            mal_d      = sat_add(mal_q, CntOne);
            res.status = sfp_pkg::StatusMalformed;
            res.cause  = sfp_pkg::CauseUntermLoss;
            res.loss   = 1'b1;
          end else begin
            inc_d      = sat_add(inc_q, CntOne);
            res.status = sfp_pkg::StatusIncomplete;
            res.cause  = sfp_pkg::CauseUnterminated;
          end
        end else if (pending_loss_q) begin
          push       = 1'b1;
          mal_d      = sat_add(mal_q, CntOne);
          res.status = sfp_pkg::StatusMalformed;
          res.cause  = sfp_pkg::CauseLossNoFrame;
          res.loss   = 1'b1;
        end
        in_frame_d     = 1'b0;
        frame_loss_d   = 1'b0;
        pending_loss_d = 1'b0;
        next_len_d     = CntOne;
      end
      sfp_pkg::OpReset: begin
        in_frame_d     = 1'b0;
        frame_loss_d   = 1'b0;
        pending_loss_d = 1'b0;
        next_len_d     = CntOne;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Record carries the counter values after this step.
  assign push_o              = accept && push;
  assign rec_o.res           = res;
  assign rec_o.then_start    = then_start;
  assign rec_o.frames_ok     = sfp_pkg::CntOutW'(cf_d);
  assign rec_o.bytes_ok      = sfp_pkg::CntOutW'(cb_d);
  assign rec_o.frames_unterm = sfp_pkg::CntOutW'(inc_d);
  assign rec_o.frames_bad    = sfp_pkg::CntOutW'(mal_d);
  assign rec_o.rt_passed     = sfp_pkg::CntOutW'(rt_d);
  assign rec_o.loss_events   = sfp_pkg::CntOutW'(le_d);

  // State registers update only on an accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q     <= 1'b0;
      frame_loss_q   <= 1'b0;
      pending_loss_q <= 1'b0;
      next_len_q     <= CntOne;
      cf_q  <= '0;
      cb_q  <= '0;
      inc_q <= '0;
      mal_q <= '0;
      rt_q  <= '0;
      le_q  <= '0;
    end else if (accept) begin
      in_frame_q     <= in_frame_d;
      frame_loss_q   <= frame_loss_d;
      pending_loss_q <= pending_loss_d;
      next_len_q     <= next_len_d;
      cf_q  <= cf_d;
      cb_q  <= cb_d;
      inc_q <= inc_d;
      mal_q <= mal_d;
      rt_q  <= rt_d;
      le_q  <= le_d;
    end
  end

`ifndef SYNTHESIS
  // Pending loss only exists while no frame is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_frame_q && pending_loss_q))
    else $error("pending loss held inside a frame");
  // Frame loss is only kept for an open frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni) frame_loss_q |-> in_frame_q)
    else $error("frame loss set without an open frame");
  // Outside a frame the next length restarts at one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_frame_q |-> next_len_q == CntOne)
    else $error("frame length not cleared outside a frame");
`endif

endmodule

`default_nettype wire

[rtl/core/sfp_fifo.sv]
// Two-entry queue of result records between the front and back ends.
`default_nettype none

module sfp_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sfp_pkg::rec_t push_rec_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output sfp_pkg::rec_t      pop_rec_o
);

  sfp_pkg::rec_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o    = count_q == 2'd2;
  assign empty_o   = count_q == 2'd0;
  assign pop_rec_o = mem_q[rd_ptr_q];

  // Storage writes.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from an empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("queue fill level out of range");
`endif

endmodule

`default_nettype wire

[rtl/core/sfp_back.sv]
// Back end: drains the queue into the output register, splitting nested starts in two.
`default_nettype none

module sfp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire sfp_pkg::rec_t q_rec_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sfp_pkg::rec_t      out_rec_o
);

  logic          out_valid_q;
  logic          second_q;
  sfp_pkg::rec_t out_q;
  logic          load_ok;
  sfp_pkg::res_t start_res;

  // First byte of the frame that follows a nested-start close.
  always_comb begin
    start_res.kind     = sfp_pkg::KindFrame;
    start_res.out_byte = sfp_pkg::ByteSysexStart;
    start_res.last     = 1'b0;
    start_res.status   = sfp_pkg::StatusNone;
    start_res.cause    = sfp_pkg::CauseNone;
    start_res.loss     = 1'b0;
  end

  assign load_ok     = !out_valid_q || out_ready_i;
  assign pop_o       = load_ok && !second_q && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_q;

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else if (load_ok) begin
      if (second_q) begin
        out_valid_q <= 1'b1;
        second_q    <= 1'b0;
      end else if (!q_empty_i) begin
        out_valid_q <= 1'b1;
        second_q    <= q_rec_i.then_start;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload; the start byte keeps the counters of its step.
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      if (second_q) begin
        out_q.res        <= start_res;
        out_q.then_start <= 1'b0;
      end else if (!q_empty_i) begin
        out_q <= q_rec_i;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      second_q |-> out_valid_q && out_q.res.kind == sfp_pkg::KindClose)
    else $error("start byte pending without a shown close");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_o |-> !second_q)
    else $error("queue popped while a start byte is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && !out_q.res.last |-> out_q.res.status == sfp_pkg::StatusNone)
    else $error("status set on a result that does not end a frame");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      second_q && out_ready_i |=> out_valid_q && out_q.res.out_byte == sfp_pkg::ByteSysexStart)
    else $error("start byte not shown after nested-start close");
`endif

endmodule

`default_nettype wire

[rtl/core/sysex_frame_parser_top.sv]
// SysEx frame parser top level: front end, request queue and back end.
//
// Input channel (in_valid_i / in_ready_o) takes one request per cycle, unless
// stalled: a MIDI byte, a data-loss notice, an end of capture or a parse reset
// (op_i). Output channel (out_valid_o / out_ready_i) delivers results: realtime
// bytes, frame bytes and frame close items, each with the counter values after
// the step that produced it.
// A result passes through the queue and the output register after its request
// is accepted, and is held there until out_ready_i takes it. Throughput is
// one request per cycle while the queue is not full; a nested frame start gives
// two results from one queue entry, so the queue can fill and the input stall.
// Requests that give no result place nothing in the queue.
// The front end stalls (in_ready_o low) only when the queue is full: while the
// receiver holds out_ready_i low, or after a nested start. A stalled result
// stays on the output unchanged.
// Reset clears frame state, all counters, the queue and the output register;
// no request is taken while reset is asserted.
`default_nettype none

module sysex_frame_parser_top #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_byte_o,
  output logic             frame_last_o,
  output logic [1:0]       frame_status_o,
  output logic [3:0]       cause_o,
  output logic             loss_flag_o,
  output logic [31:0]      frames_ok_o,
  output logic [31:0]      bytes_ok_o,
  output logic [31:0]      frames_unterm_o,
  output logic [31:0]      frames_bad_o,
  output logic [31:0]      rt_passed_o,
  output logic [31:0]      loss_events_o
);

  logic          q_full, q_empty, push, pop;
  sfp_pkg::rec_t push_rec, pop_rec, out_rec;

  sfp_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .data_byte_i(data_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  sfp_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rec_i(push_rec),
    .full_o    (q_full),
    .pop_i     (pop),
    .empty_o   (q_empty),
    .pop_rec_o (pop_rec)
  );

  sfp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_rec_i    (pop_rec),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rec_o  (out_rec)
  );

  // Unpack the result record onto the output ports.
  assign kind_o          = out_rec.res.kind;
  assign out_byte_o      = out_rec.res.out_byte;
  assign frame_last_o    = out_rec.res.last;
  assign frame_status_o  = out_rec.res.status;
  assign cause_o         = out_rec.res.cause;
  assign loss_flag_o     = out_rec.res.loss;
  assign frames_ok_o     = out_rec.frames_ok;
  assign bytes_ok_o      = out_rec.bytes_ok;
  assign frames_unterm_o = out_rec.frames_unterm;
  assign frames_bad_o    = out_rec.frames_bad;
  assign rt_passed_o     = out_rec.rt_passed;
  assign loss_events_o   = out_rec.loss_events;

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the SysEx frame parser, with a scoreboard class and driver tasks.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CountW      = 32;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned RandomItems = 1700;
  localparam int unsigned IdlePct     = 32;

  // Clock, reset and the ports of the block.
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  sfp_pkg::op_e      op        = sfp_pkg::OpByte;
  logic [7:0]        data_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        kind;
  logic [7:0]        out_byte;
  logic              frame_last;
  logic [1:0]        frame_status;
  logic [3:0]        cause;
  logic              loss_flag;
  sfp_pkg::cnt_out_t frames_ok;
  sfp_pkg::cnt_out_t bytes_ok;
  sfp_pkg::cnt_out_t frames_unterm;
  sfp_pkg::cnt_out_t frames_bad;
  sfp_pkg::cnt_out_t rt_passed;
  sfp_pkg::cnt_out_t loss_events;

  // One result of the parser with the counter values that travel with it.
  typedef struct packed {
    sfp_pkg::kind_e    kind;
    logic [7:0]        out_byte;
    logic              last;
    sfp_pkg::status_e  status;
    sfp_pkg::cause_e   cause;
    logic              loss;
    sfp_pkg::cnt_out_t frames_ok;
    sfp_pkg::cnt_out_t bytes_ok;
    sfp_pkg::cnt_out_t frames_unterm;
    sfp_pkg::cnt_out_t frames_bad;
    sfp_pkg::cnt_out_t rt_passed;
    sfp_pkg::cnt_out_t loss_events;
  } frame_result_t;

  // Framing predictor and store of awaited results.
  class sysex_scoreboard;
    frame_result_t   awaited[$];
    int unsigned     failures;
    int unsigned     results_seen;
    int unsigned     kind_seen[3];
    bit              in_frame;
    bit              frame_loss;
    bit              pending_loss;
    longint unsigned frame_len;
    longint unsigned n_complete;
    longint unsigned n_complete_bytes;
    longint unsigned n_incomplete;
    longint unsigned n_malformed;
    longint unsigned n_realtime;
    longint unsigned n_loss;
    longint unsigned count_max;

    function new();
      count_max = (64'd1 << CountW) - 64'd1;
      clear_frame();
      n_complete = 0;
      n_complete_bytes = 0;
      n_incomplete = 0;
      n_malformed = 0;
      n_realtime = 0;
      n_loss = 0;
      failures = 0;
      results_seen = 0;
      kind_seen = '{0, 0, 0};
    endfunction

    function void clear_frame();
      in_frame = 0;
      frame_loss = 0;
      pending_loss = 0;
      frame_len = 0;
    endfunction

    function longint unsigned sat_add(longint unsigned a, longint unsigned b);
      if (a >= count_max || b > count_max - a) return count_max;
      return a + b;
    endfunction

    function frame_result_t make_result(sfp_pkg::kind_e k, logic [7:0] b, logic last,
                                        sfp_pkg::status_e s, sfp_pkg::cause_e c,
                                        logic loss);
      frame_result_t r;
      r = '0;
      r.kind = k;
      r.out_byte = b;
      r.last = last;
      r.status = s;
      r.cause = c;
      r.loss = loss;
      return r;
    endfunction

    // Work out what an accepted request causes and queue it.
    function void note_request(sfp_pkg::op_e req_op, logic [7:0] b);
      frame_result_t step_res[$];
      frame_result_t r;
      case (req_op)
        sfp_pkg::OpByte: begin
          if (b >= sfp_pkg::ByteRealtimeMin) begin
            n_realtime = sat_add(n_realtime, 1);
            step_res = {step_res, make_result(sfp_pkg::KindRealtime, b, 0,
                                              sfp_pkg::StatusNone, sfp_pkg::CauseNone, 0)};
          end else if (!in_frame) begin
            if (b == sfp_pkg::ByteSysexStart) begin
              in_frame = 1;
              frame_len = 1;
              frame_loss = pending_loss;
              pending_loss = 0;
              step_res = {step_res, make_result(sfp_pkg::KindFrame, b, 0,
                                                sfp_pkg::StatusNone, sfp_pkg::CauseNone,
                                                frame_loss)};
            end else begin
              n_malformed = sat_add(n_malformed, 1);
              step_res = {step_res, make_result(sfp_pkg::KindFrame, b, 1,
                                                sfp_pkg::StatusMalformed,
                                                (b == sfp_pkg::ByteSysexEnd) ?
                                                sfp_pkg::CauseStrayEnd :
                                                sfp_pkg::CauseStrayByte, 0)};
            end
          end else if (b == sfp_pkg::ByteSysexStart) begin
            // A nested start closes the open frame and opens a clean one.
            n_malformed = sat_add(n_malformed, 1);
            step_res = {step_res, make_result(sfp_pkg::KindClose, 8'h00, 1,
                                              sfp_pkg::StatusMalformed,
                                              sfp_pkg::CauseNestedStart, frame_loss)};
            frame_len = 1;
            frame_loss = 0;
            step_res = {step_res, make_result(sfp_pkg::KindFrame, b, 0,
                                              sfp_pkg::StatusNone, sfp_pkg::CauseNone, 0)};
          end else begin
            frame_len = sat_add(frame_len, 1);
            if (b == sfp_pkg::ByteSysexEnd) begin
              if (frame_loss) begin
                n_malformed = sat_add(n_malformed, 1);
                step_res = {step_res, make_result(sfp_pkg::KindFrame, b, 1,
                                                  sfp_pkg::StatusMalformed,
                                                  sfp_pkg::CauseLoss, 1)};
              end else begin
                n_complete = sat_add(n_complete, 1);
                n_complete_bytes = sat_add(n_complete_bytes, frame_len);
                step_res = {step_res, make_result(sfp_pkg::KindFrame, b, 1,
                                                  sfp_pkg::StatusComplete,
                                                  sfp_pkg::CauseNone, 0)};
              end
              in_frame = 0;
              frame_loss = 0;
              frame_len = 0;
            end else if (b >= sfp_pkg::ByteStatusMin) begin
              n_malformed = sat_add(n_malformed, 1);
              step_res = {step_res, make_result(sfp_pkg::KindFrame, b, 1,
                                                sfp_pkg::StatusMalformed,
                                                sfp_pkg::CauseStatusInside, frame_loss)};
              in_frame = 0;
              frame_loss = 0;
              frame_len = 0;
            end else begin
              step_res = {step_res, make_result(sfp_pkg::KindFrame, b, 0,
                                                sfp_pkg::StatusNone, sfp_pkg::CauseNone,
                                                frame_loss)};
            end
          end
        end
        sfp_pkg::OpLoss: begin
          n_loss = sat_add(n_loss, 1);
          if (in_frame) frame_loss = 1;
          else pending_loss = 1;
        end
        sfp_pkg::OpEnd: begin
          if (in_frame) begin
            if (frame_loss) begin
              n_malformed = sat_add(n_malformed, 1);
              step_res = {step_res, make_result(sfp_pkg::KindClose, 8'h00, 1,
                                                sfp_pkg::StatusMalformed,
                                                sfp_pkg::CauseUntermLoss, 1)};
            end else begin
              n_incomplete = sat_add(n_incomplete, 1);
              step_res = {step_res, make_result(sfp_pkg::KindClose, 8'h00, 1,
                                                sfp_pkg::StatusIncomplete,
                                                sfp_pkg::CauseUnterminated, 0)};
            end
          end else if (pending_loss) begin
            n_malformed = sat_add(n_malformed, 1);
            step_res = {step_res, make_result(sfp_pkg::KindClose, 8'h00, 1,
                                              sfp_pkg::StatusMalformed,
                                              sfp_pkg::CauseLossNoFrame, 1)};
          end
          clear_frame();
        end
        default: begin
          clear_frame();
        end
      endcase
      // Every result of the step carries the counters as they stand after it.
      foreach (step_res[i]) begin
        r = step_res[i];
        r.frames_ok = sfp_pkg::cnt_out_t'(n_complete);
        r.bytes_ok = sfp_pkg::cnt_out_t'(n_complete_bytes);
        r.frames_unterm = sfp_pkg::cnt_out_t'(n_incomplete);
        r.frames_bad = sfp_pkg::cnt_out_t'(n_malformed);
        r.rt_passed = sfp_pkg::cnt_out_t'(n_realtime);
        r.loss_events = sfp_pkg::cnt_out_t'(n_loss);
        awaited = {awaited, r};
      end
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        failures++;
        $display("%0t: mismatch in %s, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    // Compare an accepted result with the oldest awaited one.
    function void check_result(frame_result_t got);
      frame_result_t exp_r;
      results_seen++;
      if (got.kind <= sfp_pkg::KindClose) kind_seen[got.kind]++;
      if (awaited.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                 $time, got.kind, got.out_byte);
        return;
      end
      exp_r = awaited.pop_front();
      compare_field("kind", exp_r.kind, got.kind);
      compare_field("out_byte", exp_r.out_byte, got.out_byte);
      compare_field("frame_last", exp_r.last, got.last);
      compare_field("frame_status", exp_r.status, got.status);
      compare_field("cause", exp_r.cause, got.cause);
      compare_field("loss_flag", exp_r.loss, got.loss);
      compare_field("frames_ok", exp_r.frames_ok, got.frames_ok);
      compare_field("bytes_ok", exp_r.bytes_ok, got.bytes_ok);
      compare_field("frames_unterm", exp_r.frames_unterm, got.frames_unterm);
      compare_field("frames_bad", exp_r.frames_bad, got.frames_bad);
      compare_field("rt_passed", exp_r.rt_passed, got.rt_passed);
      compare_field("loss_events", exp_r.loss_events, got.loss_events);
    endfunction
  endclass

  sysex_scoreboard sb = new();

  int unsigned sent_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = IdlePct;
  int unsigned rx_idle_pct = IdlePct;
  int unsigned hold_token  = 0;

  sysex_frame_parser_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (op),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .out_byte_o     (out_byte),
    .frame_last_o   (frame_last),
    .frame_status_o (frame_status),
    .cause_o        (cause),
    .loss_flag_o    (loss_flag),
    .frames_ok_o    (frames_ok),
    .bytes_ok_o     (bytes_ok),
    .frames_unterm_o(frames_unterm),
    .frames_bad_o   (frames_bad),
    .rt_passed_o    (rt_passed),
    .loss_events_o  (loss_events)
  );

  // Free-running clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit in cycles.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever the token moves.
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{kind: sfp_pkg::kind_e'(kind), out_byte: out_byte, last: frame_last,
                        status: sfp_pkg::status_e'(frame_status),
                        cause: sfp_pkg::cause_e'(cause), loss: loss_flag,
                        frames_ok: frames_ok, bytes_ok: bytes_ok,
                        frames_unterm: frames_unterm, frames_bad: frames_bad,
                        rt_passed: rt_passed, loss_events: loss_events});
    end
  end

  // Offer one request, after a random gap, and hold it until it is taken.
  task automatic send_request(sfp_pkg::op_e req_op, logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    op = req_op;
    data_byte = b;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req_op, b);
    sent_count++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_request(sfp_pkg::OpByte, b);
  endtask

  // Event requests carry a random byte that the block must ignore.
  task automatic send_event(sfp_pkg::op_e req_op);
    send_request(req_op, 8'($urandom_range(255)));
  endtask

  // Stop offering and wait until every awaited result has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // A frame with random content and a random way of ending.
  task automatic send_frame();
    int unsigned len;
    int unsigned pick;
    if ($urandom_range(9) == 0) send_event(sfp_pkg::OpLoss);
    send_byte(sfp_pkg::ByteSysexStart);
    len = $urandom_range(10);
    if ($urandom_range(49) == 0) len = $urandom_range(40, 20);
    repeat (len) begin
      pick = $urandom_range(99);
      if (pick < 8) send_byte(8'($urandom_range(255, 248)));
      else if (pick < 11) send_event(sfp_pkg::OpLoss);
      else send_byte(8'($urandom_range(127)));
    end
    pick = $urandom_range(99);
    if (pick < 65) send_byte(sfp_pkg::ByteSysexEnd);
    else if (pick < 73) send_byte(8'($urandom_range(246, 128)));
    else if (pick < 80) send_byte(sfp_pkg::ByteSysexStart);
    else if (pick < 88) send_event(sfp_pkg::OpEnd);
    else if (pick < 93) send_event(sfp_pkg::OpReset);
  endtask

  // Mostly frames, the rest arbitrary requests.
  task automatic send_random(int unsigned count);
    int unsigned stop_at;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      if ($urandom_range(99) < 80) send_frame();
      else send_request(sfp_pkg::op_e'($urandom_range(3)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int unsigned directed_count;

    // Reset is held, then released at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: realtime extremes, stray bytes and every way a frame ends.
    send_byte(8'hF8);
    send_byte(8'hFF);
    send_byte(sfp_pkg::ByteSysexEnd);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(sfp_pkg::ByteSysexStart);
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(8'h7F);
    send_byte(sfp_pkg::ByteSysexEnd);
    send_byte(sfp_pkg::ByteSysexStart);
    send_byte(sfp_pkg::ByteSysexStart);
    send_byte(8'h12);
    send_byte(8'hF6);
    send_event(sfp_pkg::OpLoss);
    send_event(sfp_pkg::OpEnd);
    send_event(sfp_pkg::OpLoss);
    send_byte(sfp_pkg::ByteSysexStart);
    send_byte(8'h01);
    send_byte(sfp_pkg::ByteSysexEnd);
    send_byte(sfp_pkg::ByteSysexStart);
    send_event(sfp_pkg::OpLoss);
    send_event(sfp_pkg::OpEnd);
    send_byte(sfp_pkg::ByteSysexStart);
    send_byte(8'h55);
    send_event(sfp_pkg::OpEnd);
    send_byte(sfp_pkg::ByteSysexStart);
    send_event(sfp_pkg::OpReset);
    send_byte(8'h33);
    send_event(sfp_pkg::OpEnd);
    directed_count = sent_count;

    // Random part, with a normal phase first.
    send_random(400);

    // Receiver holds off while requests keep coming, so the queue fills up.
    tx_idle_pct = 0;
    hold_token++;
    send_random(300);
    tx_idle_pct = IdlePct;

    // Sender pauses until everything has come out.
    wait_drained();

    // A stretch with no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(300);
    tx_idle_pct = IdlePct;
    rx_idle_pct = IdlePct;

    send_random(RandomItems - 1000);
    send_event(sfp_pkg::OpEnd);

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d requests (%0d directed), %0d results:",
             sent_count, directed_count, sb.results_seen);
    $display("  %0d realtime, %0d frame bytes, %0d close items; frames %0d complete,",
             sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.n_complete);
    $display("  %0d incomplete, %0d malformed; %0d loss notices.",
             sb.n_incomplete, sb.n_malformed, sb.n_loss);
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
